// ===== sv/liveness_table_least_loaded_unit_macros.svh =====
// ---------------------------------------------------------------------------
// liveness_table_least_loaded_unit_macros
// assertion helpers for the liveness table
// ---------------------------------------------------------------------------
`ifndef LIVENESS_TABLE_LEAST_LOADED_UNIT_MACROS_SVH
`define LIVENESS_TABLE_LEAST_LOADED_UNIT_MACROS_SVH

// property must hold at every edge outside reset
`define LTL_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be seen outside reset
`define LTL_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== sv/ltl_pkg.sv =====
// ---------------------------------------------------------------------------
// ltl_pkg
// shared types and constants of the liveness table
// ---------------------------------------------------------------------------
package ltl_pkg;
    localparam int DefEntries   = 16;
    localparam int TimeW        = 48;
    localparam int LoadW        = 15;
    localparam int SlotW        = 16 + 8 + 16 + LoadW + TimeW;
    localparam logic [31:0] StaleReset = 32'd10000;
    localparam logic [LoadW-1:0] LoadMax = {LoadW{1'b1}};

    typedef enum logic [3:0] {
        ACT_REGISTER = 4'd0,
        ACT_BEAT     = 4'd1,
        ACT_SETLOAD  = 4'd2,
        ACT_JOIN     = 4'd3,
        ACT_LEAVE    = 4'd4,
        ACT_DEREG    = 4'd5,
        ACT_PRUNE    = 4'd6,
        ACT_LEAST    = 4'd7,
        ACT_LOOKUP   = 4'd8
    } action_t;

    typedef struct packed {
        logic [15:0]      node;
        logic [7:0]       group;
        logic [15:0]      port;
        logic [LoadW-1:0] load;
        logic [TimeW-1:0] seen;
    } slot_t;
endpackage

// ===== sv/ltl_ram.sv =====
// ---------------------------------------------------------------------------
// ltl_ram
// simple dual port synchronous ram (one write port, one read port) with registered read
// ---------------------------------------------------------------------------
module ltl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== sv/liveness_table_least_loaded_unit.sv =====
// ---------------------------------------------------------------------------
// liveness_table_least_loaded_unit
// membership table with heartbeat, prune and least-loaded selection
// ---------------------------------------------------------------------------
// one item at a time: a new input is taken only in idle, once the last result is taken
// each item scans every slot through the single read port of the slot memory,
//   then writes back and holds its result until out_ready
// reset: valid bits cleared at once, no clearing pass, stale limit 10000
module liveness_table_least_loaded_unit
    import ltl_pkg::*;
#(
    parameter int ENTRIES = DefEntries
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [31:0]       cfg_wdata,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [3:0]        action,
    input  logic [15:0]       node_key,
    input  logic [7:0]        group_key,
    input  logic [15:0]       port_value,
    input  logic signed [15:0] load_value,
    input  logic [TimeW-1:0]  now_time,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              ok,
    output logic              table_full,
    output logic [4:0]        evicted_count,
    output logic [15:0]       hit_node,
    output logic [7:0]        hit_group,
    output logic [15:0]       hit_port,
    output logic [LoadW-1:0]  hit_load,
    output logic [4:0]        live_count
);
`include "liveness_table_least_loaded_unit_macros.svh"
    localparam int AW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_SCAN = 5'b00010,
        ST_DONE = 5'b00100,
        ST_WRIT = 5'b01000,
        ST_OUT  = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic [31:0] stale_reg;
    logic [ENTRIES-1:0] valid_reg;
    logic [CW-1:0] live_reg;
    logic [CW-1:0] idx_reg;      // issue index, one ahead of the data
    logic          rv_reg;       // read data valid
    logic [AW-1:0] ridx_reg;     // index of data in rdata
    action_t act_reg;
    logic [15:0] key_reg;
    logic [7:0]  grp_reg;
    logic [15:0] port_reg;
    logic [15:0] lraw_reg;
    logic [TimeW-1:0] now_reg;
    logic found_reg;
    logic [AW-1:0] fidx_reg;
    slot_t fslot_reg;
    logic [CW-1:0] ev_reg;

    logic we;
    logic [AW-1:0] waddr;
    slot_t wdata, rdata;
    logic [AW-1:0] raddr;

    ltl_ram #(.WIDTH(SlotW), .DEPTH(ENTRIES)) u_ram (
        .clk  (clk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .raddr(raddr),
        .rdata(rdata)
    );

    assign in_ready = (state_reg == ST_IDLE);
    assign raddr = idx_reg[AW-1:0];

    // per-slot test during the scan
    logic          live_hit;
    logic          match;
    logic [TimeW-1:0] age;
    logic          stale;
    logic          better;
    assign live_hit = rv_reg && valid_reg[ridx_reg];
    assign age = now_reg - rdata.seen;
    assign stale = (now_reg >= rdata.seen) && (age > {16'd0, stale_reg});
    assign better = !found_reg || (rdata.load < fslot_reg.load) ||
                    ((rdata.load == fslot_reg.load) && (rdata.node < fslot_reg.node));

    always_comb
    begin
        match = 1'b0;
        unique case (act_reg)
            ACT_LEAST: match = live_hit && (rdata.group == grp_reg) && better;
            ACT_PRUNE: match = 1'b0;
            default:   match = live_hit && (rdata.node == key_reg) && !found_reg;
        endcase
    end

    // lowest free slot, a priority search over valid bits
    logic          free_any;
    logic [AW-1:0] free_idx;
    always_comb
    begin
        free_any = 1'b0;
        free_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_any = 1'b1;
                free_idx = AW'(i);
            end
        end
    end

    // modified slot for the write back
    slot_t upd;
    always_comb
    begin
        upd = fslot_reg;
        upd.seen = now_reg;
        unique case (act_reg)
            ACT_REGISTER:
            begin
                if (!found_reg)
                begin
                    upd.node = key_reg;
                    upd.load = '0;
                end
                upd.group = grp_reg;
                upd.port = port_reg;
            end
            ACT_SETLOAD: upd.load = lraw_reg[15] ? '0 : lraw_reg[LoadW-1:0];
            ACT_JOIN:    if (fslot_reg.load != LoadMax) upd.load = fslot_reg.load + 1'b1;
            ACT_LEAVE:   if (fslot_reg.load != '0) upd.load = fslot_reg.load - 1'b1;
            default:     upd.seen = now_reg;
        endcase
    end

    logic is_mod;
    assign is_mod = (act_reg == ACT_BEAT) || (act_reg == ACT_SETLOAD) ||
                    (act_reg == ACT_JOIN) || (act_reg == ACT_LEAVE);
    logic reg_ok;
    assign reg_ok = found_reg || free_any;

    always_comb
    begin
        we = 1'b0;
        waddr = fidx_reg;
        wdata = upd;
        if (state_reg == ST_WRIT)
        begin
            if (act_reg == ACT_REGISTER)
            begin
                we = reg_ok;
                waddr = found_reg ? fidx_reg : free_idx;
            end
            else
            begin
                we = is_mod && found_reg;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (in_valid) state_next = ST_SCAN;
            ST_SCAN: if (rv_reg && (ridx_reg == AW'(ENTRIES - 1))) state_next = ST_DONE;
            ST_DONE: state_next = ST_WRIT;
            ST_WRIT: state_next = ST_OUT;
            ST_OUT:  if (out_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            stale_reg <= StaleReset;
            valid_reg <= '0;
            live_reg  <= '0;
            idx_reg   <= '0;
            rv_reg    <= 1'b0;
            ridx_reg  <= '0;
            found_reg <= 1'b0;
            ev_reg    <= '0;
            out_valid <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                stale_reg <= cfg_wdata;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        idx_reg   <= '0;
                        rv_reg    <= 1'b0;
                        found_reg <= 1'b0;
                        ev_reg    <= '0;
                    end
                end
                ST_SCAN:
                begin
                    if (idx_reg != CW'(ENTRIES))
                    begin
                        idx_reg <= idx_reg + 1'b1;
                        rv_reg <= 1'b1;
                        ridx_reg <= idx_reg[AW-1:0];
                    end
                    else
                    begin
                        rv_reg <= 1'b0;
                    end
                    if (match)
                    begin
                        found_reg <= 1'b1;
                        fidx_reg <= ridx_reg;
                        fslot_reg <= rdata;
                    end
                    if ((act_reg == ACT_PRUNE) && live_hit && stale)
                    begin
                        valid_reg[ridx_reg] <= 1'b0;
                        ev_reg <= ev_reg + 1'b1;
                        live_reg <= live_reg - 1'b1;
                    end
                end
                ST_DONE: rv_reg <= 1'b0;
                ST_WRIT:
                begin
                    out_valid <= 1'b1;
                    if ((act_reg == ACT_REGISTER) && !found_reg && free_any)
                    begin
                        valid_reg[free_idx] <= 1'b1;
                        live_reg <= live_reg + 1'b1;
                    end
                    if ((act_reg == ACT_DEREG) && found_reg)
                    begin
                        valid_reg[fidx_reg] <= 1'b0;
                        live_reg <= live_reg - 1'b1;
                    end
                end
                ST_OUT: if (out_ready) out_valid <= 1'b0;
                default: out_valid <= 1'b0;
            endcase
        end
    end

    // input capture and result payload
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            act_reg  <= action_t'(action);
            key_reg  <= node_key;
            grp_reg  <= group_key;
            port_reg <= port_value;
            lraw_reg <= load_value;
            now_reg  <= now_time;
        end
        if (state_reg == ST_WRIT)
        begin
            ok <= 1'b0;
            table_full <= 1'b0;
            evicted_count <= '0;
            hit_node <= '0;
            hit_group <= '0;
            hit_port <= '0;
            hit_load <= '0;
            priority case (act_reg)
                ACT_REGISTER:
                begin
                    ok <= reg_ok;
                    table_full <= !reg_ok;
                end
                ACT_BEAT, ACT_SETLOAD, ACT_JOIN, ACT_LEAVE, ACT_DEREG: ok <= found_reg;
                ACT_PRUNE:
                begin
                    ok <= 1'b1;
                    evicted_count <= 5'(ev_reg);
                end
                ACT_LEAST, ACT_LOOKUP:
                begin
                    ok <= found_reg;
                    if (found_reg)
                    begin
                        hit_node <= fslot_reg.node;
                        hit_group <= fslot_reg.group;
                        hit_port <= fslot_reg.port;
                        hit_load <= fslot_reg.load;
                    end
                end
                default: ok <= 1'b0;
            endcase
        end
    end

    assign live_count = 5'(live_reg);

    `LTL_ASSERT(a_live_match, clk, rst_n, live_reg == CW'($countones(valid_reg)), "live count drift")
    `LTL_NEVER(a_no_acc_busy, clk, rst_n, out_valid && in_ready, "accept while result pending")
    `LTL_ASSERT(a_onehot, clk, rst_n, $onehot(state_reg), "state not one-hot")
    `LTL_ASSERT(a_we_phase, clk, rst_n, we |-> (state_reg == ST_WRIT), "write outside write back")
endmodule

// ===== test/testbench.sv =====
// ---------------------------------------------------------------------------
// testbench
// drives random and directed table operations into the liveness table and
// checks every result against a behavioural copy of the table
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
    import ltl_pkg::*;

    localparam int NSLOT = DefEntries;
    localparam int LIMIT_CYCLES = 400000;

    typedef struct packed {
        logic [3:0]        action;
        logic [15:0]       node_key;
        logic [7:0]        group_key;
        logic [15:0]       port_value;
        logic [15:0]       load_value;
        logic [TimeW-1:0]  now_time;
    } op_t;

    typedef struct packed {
        logic              ok;
        logic              table_full;
        logic [4:0]        evicted_count;
        logic [15:0]       hit_node;
        logic [7:0]        hit_group;
        logic [15:0]       hit_port;
        logic [LoadW-1:0]  hit_load;
        logic [4:0]        live_count;
    } answer_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [31:0] cfg_wdata = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [3:0] action = '0;
    logic [15:0] node_key = '0;
    logic [7:0] group_key = '0;
    logic [15:0] port_value = '0;
    logic signed [15:0] load_value = '0;
    logic [TimeW-1:0] now_time = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic ok, table_full;
    logic [4:0] evicted_count, live_count;
    logic [15:0] hit_node, hit_port;
    logic [7:0] hit_group;
    logic [LoadW-1:0] hit_load;

    // shadow table
    logic [31:0] stale_ms;
    logic tbl_valid [NSLOT];
    slot_t tbl [NSLOT];

    op_t pending_ops[$];
    answer_t expected_answers[$];
    int failures = 0;
    int cycle_count = 0;
    bit calm = 1'b0;
    logic [TimeW-1:0] clock_ms = 48'd5000;

    liveness_table_least_loaded_unit dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_ready(in_ready), .action(action),
        .node_key(node_key), .group_key(group_key), .port_value(port_value),
        .load_value(load_value), .now_time(now_time), .out_valid(out_valid),
        .out_ready(out_ready), .ok(ok), .table_full(table_full),
        .evicted_count(evicted_count), .hit_node(hit_node), .hit_group(hit_group),
        .hit_port(hit_port), .hit_load(hit_load), .live_count(live_count)
    );

    always #6 clk = ~clk;

    function automatic int find_slot(logic [15:0] key);
        for (int i = 0; i < NSLOT; i++)
            if (tbl_valid[i] && tbl[i].node == key)
                return i;
        return -1;
    endfunction

    function automatic answer_t apply_op(op_t op);
        answer_t a;
        int s;
        int ev;
        int live;
        a = '0;
        s = -1;
        ev = 0;
        live = 0;
        case (op.action)
            ACT_REGISTER:
            begin
                s = find_slot(op.node_key);
                if (s < 0)
                begin
                    for (int i = 0; i < NSLOT; i++)
                        if (!tbl_valid[i] && s < 0)
                            s = i;
                    if (s >= 0)
                    begin
                        tbl_valid[s] = 1'b1;
                        tbl[s].node = op.node_key;
                        tbl[s].load = '0;
                    end
                end
                if (s < 0)
                    a.table_full = 1'b1;
                else
                begin
                    tbl[s].group = op.group_key;
                    tbl[s].port = op.port_value;
                    tbl[s].seen = op.now_time;
                    a.ok = 1'b1;
                end
            end
            ACT_BEAT, ACT_SETLOAD, ACT_JOIN, ACT_LEAVE:
            begin
                s = find_slot(op.node_key);
                if (s >= 0)
                begin
                    if (op.action == ACT_SETLOAD)
                        tbl[s].load = op.load_value[15] ? '0 : op.load_value[14:0];
                    else if (op.action == ACT_JOIN && tbl[s].load != LoadMax)
                        tbl[s].load = tbl[s].load + 1'b1;
                    else if (op.action == ACT_LEAVE && tbl[s].load != '0)
                        tbl[s].load = tbl[s].load - 1'b1;
                    tbl[s].seen = op.now_time;
                    a.ok = 1'b1;
                end
            end
            ACT_DEREG:
            begin
                s = find_slot(op.node_key);
                if (s >= 0)
                begin
                    tbl_valid[s] = 1'b0;
                    a.ok = 1'b1;
                end
            end
            ACT_PRUNE:
            begin
                for (int i = 0; i < NSLOT; i++)
                    if (tbl_valid[i] && op.now_time >= tbl[i].seen
                        && op.now_time - tbl[i].seen > {16'd0, stale_ms})
                    begin
                        tbl_valid[i] = 1'b0;
                        ev++;
                    end
                a.ok = 1'b1;
                a.evicted_count = ev[4:0];
            end
            ACT_LEAST:
            begin
                for (int i = 0; i < NSLOT; i++)
                    if (tbl_valid[i] && tbl[i].group == op.group_key)
                        if (s < 0 || tbl[i].load < tbl[s].load
                            || (tbl[i].load == tbl[s].load && tbl[i].node < tbl[s].node))
                            s = i;
            end
            ACT_LOOKUP: s = find_slot(op.node_key);
            default: ;
        endcase
        if ((op.action == ACT_LEAST || op.action == ACT_LOOKUP) && s >= 0)
        begin
            a.ok = 1'b1;
            a.hit_node = tbl[s].node;
            a.hit_group = tbl[s].group;
            a.hit_port = tbl[s].port;
            a.hit_load = tbl[s].load;
        end
        for (int i = 0; i < NSLOT; i++)
            if (tbl_valid[i])
                live++;
        a.live_count = live[4:0];
        return a;
    endfunction

    function automatic op_t make_op(logic [3:0] act, logic [15:0] key, logic [7:0] grp,
                                    logic [15:0] port, logic [15:0] ld, logic [TimeW-1:0] t);
        op_t o;
        o.action = act;
        o.node_key = key;
        o.group_key = grp;
        o.port_value = port;
        o.load_value = ld;
        o.now_time = t;
        return o;
    endfunction

    // mostly a small key and group pool so operations hit live entries
    function automatic op_t random_op();
        op_t o;
        int r;
        r = $urandom_range(0, 99);
        o.action = (r < 25) ? ACT_REGISTER : (r < 96) ? 4'($urandom_range(1, 8))
                                                      : 4'($urandom_range(9, 15));
        o.node_key = ($urandom_range(0, 9) < 8) ? 16'($urandom_range(0, 23))
                                                 : 16'($urandom);
        o.group_key = ($urandom_range(0, 9) < 8) ? 8'($urandom_range(0, 3))
                                                  : 8'($urandom);
        o.port_value = 16'($urandom);
        o.load_value = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                    : 16'($urandom_range(0, 6));
        if ($urandom_range(0, 19) == 0)
            o.now_time = {16'($urandom), 32'($urandom)};
        else
        begin
            clock_ms = clock_ms + 48'($urandom_range(0, 3000));
            o.now_time = clock_ms - 48'($urandom_range(0, 200));
        end
        return o;
    endfunction

    task automatic push_op(op_t o);
        pending_ops = {pending_ops, o};
        expected_answers = {expected_answers, apply_op(o)};
    endtask

    task automatic wait_drained();
        wait (pending_ops.size() == 0 && expected_answers.size() == 0);
        repeat (NSLOT + 10) @(posedge clk);
    endtask

    task automatic write_stale(logic [31:0] v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        stale_ms = v;
    endtask

    // driver
    always @(posedge clk)
    begin
        if (in_valid && in_ready)
            void'(pending_ops.pop_front());
        if (in_valid && !in_ready)
            ;
        else if (pending_ops.size() > (in_valid && in_ready ? 0 : 0)
                 && (calm || $urandom_range(0, 99) >= 38))
        begin
            in_valid <= 1'b1;
            {action, node_key, group_key, port_value, load_value, now_time}
                <= pending_ops[0];
        end
        else
            in_valid <= 1'b0;
        out_ready <= calm || $urandom_range(0, 99) >= 38;
    end

    // monitor
    always @(posedge clk)
    begin
        answer_t want;
        cycle_count <= cycle_count + 1;
        if (out_valid && out_ready)
        begin
            if (expected_answers.size() == 0)
            begin
                $error("result with nothing expected");
                failures++;
            end
            else
            begin
                want = expected_answers.pop_front();
                if (ok !== want.ok)
                begin
                    $error("ok exp %0d got %0d", want.ok, ok);
                    failures++;
                end
                if (table_full !== want.table_full)
                begin
                    $error("table_full exp %0d got %0d", want.table_full, table_full);
                    failures++;
                end
                if (evicted_count !== want.evicted_count)
                begin
                    $error("evicted_count exp %0d got %0d", want.evicted_count,
                           evicted_count);
                    failures++;
                end
                if (hit_node !== want.hit_node)
                begin
                    $error("hit_node exp %0d got %0d", want.hit_node, hit_node);
                    failures++;
                end
                if (hit_group !== want.hit_group)
                begin
                    $error("hit_group exp %0d got %0d", want.hit_group, hit_group);
                    failures++;
                end
                if (hit_port !== want.hit_port)
                begin
                    $error("hit_port exp %0d got %0d", want.hit_port, hit_port);
                    failures++;
                end
                if (hit_load !== want.hit_load)
                begin
                    $error("hit_load exp %0d got %0d", want.hit_load, hit_load);
                    failures++;
                end
                if (live_count !== want.live_count)
                begin
                    $error("live_count exp %0d got %0d", want.live_count, live_count);
                    failures++;
                end
            end
        end
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        logic [31:0] limits [4];
        stale_ms = StaleReset;
        for (int i = 0; i < NSLOT; i++)
        begin
            tbl_valid[i] = 1'b0;
            tbl[i] = '0;
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed: empty table, fill past capacity, load extremes, prune
        push_op(make_op(ACT_LOOKUP, 16'd7, 8'd0, 16'd0, 16'd0, 48'd0));
        push_op(make_op(ACT_LEAST, 16'd0, 8'd0, 16'd0, 16'd0, 48'd0));
        push_op(make_op(ACT_BEAT, 16'd7, 8'd0, 16'd0, 16'd0, 48'd0));
        for (int i = 0; i < NSLOT; i++)
            push_op(make_op(ACT_REGISTER, (i == 0) ? 16'hFFFF : 16'(i), 8'(i % 2 ? 255 : 0),
                            16'(i * 4099), 16'd0, 48'(i * 100)));
        push_op(make_op(ACT_REGISTER, 16'd9999, 8'd1, 16'd1, 16'd0, 48'd50));
        push_op(make_op(ACT_SETLOAD, 16'd2, 8'd0, 16'd0, 16'h8000, 48'd60));
        push_op(make_op(ACT_SETLOAD, 16'd3, 8'd0, 16'd0, 16'h7FFF, 48'd60));
        push_op(make_op(ACT_JOIN, 16'd3, 8'd0, 16'd0, 16'd0, 48'hFFFF_FFFF_FFFF));
        push_op(make_op(ACT_LEAVE, 16'hFFFF, 8'd0, 16'd0, 16'd0, 48'd70));
        push_op(make_op(ACT_LEAST, 16'd0, 8'd255, 16'd0, 16'd0, 48'd70));
        push_op(make_op(ACT_REGISTER, 16'd4, 8'd9, 16'hFFFF, 16'd0, 48'd80));
        push_op(make_op(ACT_DEREG, 16'd5, 8'd0, 16'd0, 16'd0, 48'd80));
        push_op(make_op(4'd15, 16'd5, 8'd0, 16'd0, 16'd0, 48'd80));
        push_op(make_op(ACT_PRUNE, 16'd0, 8'd0, 16'd0, 16'd0, 48'd10500));
        push_op(make_op(ACT_PRUNE, 16'd0, 8'd0, 16'd0, 16'd0, 48'hFFFF_0000_0000));
        wait_drained();

        limits[0] = 32'd0;
        limits[1] = 32'hFFFF_FFFF;
        limits[2] = 32'd2500;
        limits[3] = 32'd8000;
        for (int ph = 0; ph < 4; ph++)
        begin
            write_stale(limits[ph]);
            calm = (ph == 2);
            for (int k = 0; k < 240; k++)
                push_op(random_op());
            wait_drained();
        end

        if (failures == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
